@@ rtl/ddrd_pkg.sv @@
// Package for the differential drive ramp decoder.
// Holds beat payload types, per-side pin/duty type, command codes and defaults.
// No dependencies.
`timescale 1ns / 1ps

package ddrd_pkg;

   // Default ramp divisor (counter steps per duty step)
   localparam int RAMP_DIVISOR_DEF = 16;

   // Configuration register indexes
   localparam int CSR_ADDR_W = 1;
   localparam logic [CSR_ADDR_W-1:0] CSR_MIN_SPEED   = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_DRIVER_TYPE = 1'd1;

   // Motion command codes
   localparam logic [3:0] CMD_FWD      = 4'd0;
   localparam logic [3:0] CMD_REV      = 4'd1;
   localparam logic [3:0] CMD_STOP     = 4'd2;
   localparam logic [3:0] CMD_COAST    = 4'd3;
   localparam logic [3:0] CMD_CCW      = 4'd4;
   localparam logic [3:0] CMD_CW       = 4'd5;
   localparam logic [3:0] CMD_VEER_L   = 4'd6;
   localparam logic [3:0] CMD_VEER_R   = 4'd7;
   localparam logic [3:0] CMD_RVEER_L  = 4'd8;
   localparam logic [3:0] CMD_RVEER_R  = 4'd9;

   typedef struct packed {
      logic [3:0] command;
      logic [7:0] speed;
      logic       urgent;
   } req_type;

   typedef struct packed {
      logic       right_enable;
      logic       right_dir_a;
      logic       right_dir_b;
      logic [7:0] right_duty;
      logic       left_enable;
      logic       left_dir_a;
      logic       left_dir_b;
      logic [7:0] left_duty;
   } rsp_type;

   // Held levels of one bridge channel
   typedef struct packed {
      logic       enable;
      logic       dir_a;
      logic       dir_b;
      logic [7:0] duty;
   } side_type;

endpackage

@@ rtl/ddrd_decode.sv @@
// Command decode and ramp update for the differential drive ramp decoder.
// Computes next held pin/duty levels and next ramp state for one command.
// Depends on ddrd_pkg.
`timescale 1ns / 1ps

module ddrd_decode #(
   parameter int RAMP_DIVISOR = ddrd_pkg::RAMP_DIVISOR_DEF,
   localparam int REM_W = (RAMP_DIVISOR > 1) ? $clog2(RAMP_DIVISOR) : 1
) (
   input  ddrd_pkg::req_type  req,
   input  logic [7:0]         min_speed,
   input  logic               driver_type,
   input  logic               ramp_active,
   input  logic [7:0]         ramp_quot,
   input  logic [REM_W-1:0]   ramp_rem,
   input  ddrd_pkg::side_type right_cur,
   input  ddrd_pkg::side_type left_cur,
   output logic               ramp_active_next,
   output logic [7:0]         ramp_quot_next,
   output logic [REM_W-1:0]   ramp_rem_next,
   output ddrd_pkg::side_type right_next,
   output ddrd_pkg::side_type left_next
);
   import ddrd_pkg::*;

   localparam logic [1:0] DIR_FWD  = 2'd0;
   localparam logic [1:0] DIR_REV  = 2'd1;
   localparam logic [1:0] DIR_STOP = 2'd2;
   localparam logic [REM_W-1:0] REM_LAST = REM_W'(RAMP_DIVISOR - 1);

   // Drive one side in a direction with a duty
   function automatic side_type drive(input logic is_right, input logic [1:0] dir,
                                      input logic [7:0] duty, input logic typ,
                                      input logic [7:0] min_spd, input side_type cur);
      side_type s;
      logic     fa;
      s = cur;
      if (dir == DIR_STOP) begin
         if (!typ) begin
            s.enable = 1'b0;
            s.dir_a  = 1'b1;
            s.dir_b  = 1'b1;
            s.duty   = min_spd;
         end else begin
            s.dir_a = 1'b0;
            s.dir_b = 1'b0;
            s.duty  = 8'd0;
         end
      end else begin
         fa = is_right ^ (dir == DIR_REV) ^ typ;
         if (!typ) s.enable = 1'b1;
         s.dir_a = fa;
         s.dir_b = ~fa;
         s.duty  = duty;
      end
      return s;
   endfunction

   logic [7:0]       q0;
   logic [REM_W-1:0] r0;
   logic             step;
   logic [7:0]       q1;
   logic [REM_W-1:0] r1;
   logic [7:0]       fwd_spd;
   logic [7:0]       half_fwd;
   logic [7:0]       half_spd;

   // Ramp: start at min_speed on entry, step the counter while below target
   always_comb begin
      q0   = ramp_active ? ramp_quot : min_speed;
      r0   = ramp_active ? ramp_rem : '0;
      step = q0 < req.speed;
      q1   = q0;
      r1   = r0;
      if (step) begin
         if (r0 == REM_LAST) begin
            q1 = q0 + 8'd1;
            r1 = '0;
         end else begin
            r1 = r0 + REM_W'(1);
         end
      end
      fwd_spd  = (req.urgent || !step) ? req.speed : q1;
      half_fwd = fwd_spd >> 1;
      half_spd = req.speed >> 1;
   end

   // Decode the command into next levels
   always_comb begin
      ramp_active_next = ramp_active;
      ramp_quot_next   = ramp_quot;
      ramp_rem_next    = ramp_rem;
      right_next       = right_cur;
      left_next        = left_cur;
      unique case (req.command)
         CMD_FWD, CMD_VEER_L, CMD_VEER_R: begin
            if (!req.urgent) begin
               ramp_active_next = 1'b1;
               ramp_quot_next   = q1;
               ramp_rem_next    = r1;
            end
            right_next = drive(1'b1, DIR_FWD,
                               (req.command == CMD_VEER_R) ? half_fwd : fwd_spd,
                               driver_type, min_speed, right_cur);
            left_next  = drive(1'b0, DIR_FWD,
                               (req.command == CMD_VEER_L) ? half_fwd : fwd_spd,
                               driver_type, min_speed, left_cur);
         end
         CMD_REV: begin
            ramp_active_next = 1'b0;
            right_next = drive(1'b1, DIR_REV, req.speed, driver_type, min_speed, right_cur);
            left_next  = drive(1'b0, DIR_REV, req.speed, driver_type, min_speed, left_cur);
         end
         CMD_STOP: begin
            ramp_active_next = 1'b0;
            right_next = drive(1'b1, DIR_STOP, 8'd0, driver_type, min_speed, right_cur);
            left_next  = drive(1'b0, DIR_STOP, 8'd0, driver_type, min_speed, left_cur);
         end
         CMD_COAST: begin
            // Coast clears the ramp and, of the levels, touches only the duties
            ramp_active_next = 1'b0;
            right_next.duty  = min_speed;
            left_next.duty   = min_speed;
         end
         CMD_CCW: begin
            ramp_active_next = 1'b0;
            right_next = drive(1'b1, DIR_FWD, req.speed, driver_type, min_speed, right_cur);
            left_next  = drive(1'b0, DIR_REV, req.speed, driver_type, min_speed, left_cur);
         end
         CMD_CW: begin
            ramp_active_next = 1'b0;
            right_next = drive(1'b1, DIR_REV, req.speed, driver_type, min_speed, right_cur);
            left_next  = drive(1'b0, DIR_FWD, req.speed, driver_type, min_speed, left_cur);
         end
         CMD_RVEER_L: begin
            ramp_active_next = 1'b0;
            right_next = drive(1'b1, DIR_REV, half_spd, driver_type, min_speed, right_cur);
            left_next  = drive(1'b0, DIR_REV, req.speed, driver_type, min_speed, left_cur);
         end
         CMD_RVEER_R: begin
            ramp_active_next = 1'b0;
            right_next = drive(1'b1, DIR_REV, req.speed, driver_type, min_speed, right_cur);
            left_next  = drive(1'b0, DIR_REV, half_spd, driver_type, min_speed, left_cur);
         end
         default: begin
            // Unknown codes leave everything as it is
            ramp_active_next = ramp_active;
         end
      endcase
   end

endmodule

@@ rtl/differential_drive_ramp_decoder_core.sv @@
// Differential drive ramp decoder: two H-bridge channels from motion commands.
// Path: req beat to input register, then state/result register, then rsp beat.
// Throughput: one beat per cycle while rsp_ready keeps up; decode/ramp is combinational.
// Reset (synchronous, active high) clears pins, duties, ramp state and config.
// Depends on ddrd_pkg and ddrd_decode.
`timescale 1ns / 1ps

module differential_drive_ramp_decoder_core #(
   parameter int RAMP_DIVISOR = ddrd_pkg::RAMP_DIVISOR_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  ddrd_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output ddrd_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic [ddrd_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [7:0]                          csr_wdata
);
   import ddrd_pkg::*;

   localparam int REM_W = (RAMP_DIVISOR > 1) ? $clog2(RAMP_DIVISOR) : 1;

   logic             in_valid_ff, in_valid_in;
   req_type          in_data_ff;
   logic             out_valid_ff, out_valid_in;
   logic             advance;
   logic [7:0]       min_speed_ff;
   logic             driver_type_ff;
   logic             ramp_active_ff, ramp_active_in;
   logic [7:0]       ramp_quot_ff, ramp_quot_in;
   logic [REM_W-1:0] ramp_rem_ff, ramp_rem_in;
   side_type         right_ff, right_in;
   side_type         left_ff, left_in;

   // Handshake: the result stage moves when empty or drained
   assign advance      = !out_valid_ff || rsp_ready;
   assign req_ready    = !in_valid_ff || advance;
   assign in_valid_in  = req_ready ? req_valid : in_valid_ff;
   assign out_valid_in = advance ? in_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture the request beat
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         min_speed_ff   <= 8'd0;
         driver_type_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_MIN_SPEED:   min_speed_ff   <= csr_wdata;
            CSR_DRIVER_TYPE: driver_type_ff <= csr_wdata[0];
            default:         min_speed_ff   <= min_speed_ff;
         endcase
      end
   end

   ddrd_decode #(
      .RAMP_DIVISOR(RAMP_DIVISOR)
   ) u_decode (
      .req             (in_data_ff),
      .min_speed       (min_speed_ff),
      .driver_type     (driver_type_ff),
      .ramp_active     (ramp_active_ff),
      .ramp_quot       (ramp_quot_ff),
      .ramp_rem        (ramp_rem_ff),
      .right_cur       (right_ff),
      .left_cur        (left_ff),
      .ramp_active_next(ramp_active_in),
      .ramp_quot_next  (ramp_quot_in),
      .ramp_rem_next   (ramp_rem_in),
      .right_next      (right_in),
      .left_next       (left_in)
   );

   // Held levels double as the result register; update when a beat moves in
   always_ff @(posedge clock) begin
      if (reset) begin
         ramp_active_ff <= 1'b0;
         ramp_quot_ff   <= 8'd0;
         ramp_rem_ff    <= '0;
         right_ff       <= '0;
         left_ff        <= '0;
      end else if (advance && in_valid_ff) begin
         ramp_active_ff <= ramp_active_in;
         ramp_quot_ff   <= ramp_quot_in;
         ramp_rem_ff    <= ramp_rem_in;
         right_ff       <= right_in;
         left_ff        <= left_in;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_data.right_enable = right_ff.enable;
   assign rsp_data.right_dir_a  = right_ff.dir_a;
   assign rsp_data.right_dir_b  = right_ff.dir_b;
   assign rsp_data.right_duty   = right_ff.duty;
   assign rsp_data.left_enable  = left_ff.enable;
   assign rsp_data.left_dir_a   = left_ff.dir_a;
   assign rsp_data.left_dir_b   = left_ff.dir_b;
   assign rsp_data.left_duty    = left_ff.duty;

   // Ramp remainder stays below the divisor
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, ramp_rem_ff} < (REM_W + 1)'(RAMP_DIVISOR))
      else $error("ramp remainder out of range");

   // A stalled result stage leaves the held levels alone
   a_hold_levels: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(right_ff) && $stable(left_ff) && $stable(ramp_active_ff))
      else $error("held levels changed while stalled");

   // A full input stage that cannot move keeps its beat
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_data_ff))
      else $error("input stage lost a beat");

endmodule

@@ sim/tb_differential_drive_ramp_decoder_core.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for differential_drive_ramp_decoder_core.
// Predicts bridge pin and duty levels per command beat in a small scoreboard class.
// Depends on ddrd_pkg and the core RTL.

module tb_differential_drive_ramp_decoder_core;
   import ddrd_pkg::*;

   localparam int RIGHT     = 0;
   localparam int LEFT      = 1;
   localparam int RAMP_STEP = RAMP_DIVISOR_DEF;
   localparam int PHASE_CMDS = 85;

   typedef enum logic [1:0] {MOVE_FWD, MOVE_REV, MOVE_STOP} move_type;

   // Track held bridge levels and compare every rsp beat against them
   class bridge_level_board;
      logic [7:0]  min_speed;
      logic        driver_type;
      bit          ramping;
      int unsigned ramp_count;
      side_type    lvl [2];
      rsp_type     expected_levels [$];
      int          mismatches;

      function new();
         min_speed   = '0;
         driver_type = 1'b0;
         ramping     = 1'b0;
         ramp_count  = 0;
         lvl[RIGHT]  = '0;
         lvl[LEFT]   = '0;
         mismatches  = 0;
      endfunction

      // Advance the ramp counter one step while below the target and return the duty to use
      function int unsigned ramp_duty(int unsigned spd);
         if (!ramping) begin
            ramping    = 1'b1;
            ramp_count = (min_speed * RAMP_STEP) & 16'hFFFF;
         end
         if (ramp_count / RAMP_STEP < spd) begin
            ramp_count = (ramp_count + 1) & 16'hFFFF;
            spd        = ramp_count / RAMP_STEP;
         end
         return spd;
      endfunction

      // Set pins and duty of one side for the current driver type
      function void drive_side(int side, move_type dir, int unsigned duty);
         logic fwd_a;
         if (dir == MOVE_STOP) begin
            if (driver_type == 1'b0) begin
               lvl[side].enable = 1'b0;
               lvl[side].dir_a  = 1'b1;
               lvl[side].dir_b  = 1'b1;
               lvl[side].duty   = min_speed;
            end else begin
               lvl[side].dir_a  = 1'b0;
               lvl[side].dir_b  = 1'b0;
               lvl[side].duty   = 8'd0;
            end
            return;
         end
         fwd_a = (side == RIGHT);
         if (dir == MOVE_REV) fwd_a = ~fwd_a;
         if (driver_type) fwd_a = ~fwd_a;
         if (!driver_type) lvl[side].enable = 1'b1;
         lvl[side].dir_a = fwd_a;
         lvl[side].dir_b = ~fwd_a;
         lvl[side].duty  = (duty > 255) ? 8'd255 : 8'(duty);
      endfunction

      // Apply an accepted command beat and queue the levels it leaves
      function void apply_command(req_type r);
         int unsigned spd;
         spd = r.speed;
         case (r.command)
            CMD_FWD, CMD_VEER_L, CMD_VEER_R: begin
               if (!r.urgent) spd = ramp_duty(spd);
               if (r.command == CMD_FWD) begin
                  drive_side(RIGHT, MOVE_FWD, spd);
                  drive_side(LEFT, MOVE_FWD, spd);
               end else if (r.command == CMD_VEER_L) begin
                  drive_side(RIGHT, MOVE_FWD, spd);
                  drive_side(LEFT, MOVE_FWD, spd / 2);
               end else begin
                  drive_side(RIGHT, MOVE_FWD, spd / 2);
                  drive_side(LEFT, MOVE_FWD, spd);
               end
            end
            CMD_REV: begin
               ramping = 1'b0;
               drive_side(RIGHT, MOVE_REV, spd);
               drive_side(LEFT, MOVE_REV, spd);
            end
            CMD_STOP: begin
               ramping = 1'b0;
               drive_side(RIGHT, MOVE_STOP, 0);
               drive_side(LEFT, MOVE_STOP, 0);
            end
            CMD_COAST: begin
               ramping         = 1'b0;
               lvl[RIGHT].duty = min_speed;
               lvl[LEFT].duty  = min_speed;
            end
            CMD_CCW: begin
               ramping = 1'b0;
               drive_side(RIGHT, MOVE_FWD, spd);
               drive_side(LEFT, MOVE_REV, spd);
            end
            CMD_CW: begin
               ramping = 1'b0;
               drive_side(RIGHT, MOVE_REV, spd);
               drive_side(LEFT, MOVE_FWD, spd);
            end
            CMD_RVEER_L: begin
               ramping = 1'b0;
               drive_side(RIGHT, MOVE_REV, spd / 2);
               drive_side(LEFT, MOVE_REV, spd);
            end
            CMD_RVEER_R: begin
               ramping = 1'b0;
               drive_side(RIGHT, MOVE_REV, spd);
               drive_side(LEFT, MOVE_REV, spd / 2);
            end
            default: ;
         endcase
         expected_levels.push_back(rsp_type'({lvl[RIGHT], lvl[LEFT]}));
      endfunction

      // Print one line per mismatch, keep counting past the print cap
      task flag_mismatch(string what);
         mismatches++;
         if (mismatches <= 40) $display("%0t ns: mismatch: %s", $time, what);
      endtask

      task check_field(string name, logic [7:0] got, logic [7:0] want);
         if (got !== want)
            flag_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
      endtask

      task check_levels(rsp_type got);
         rsp_type want;
         if (expected_levels.size() == 0) begin
            flag_mismatch($sformatf("rsp beat %h with nothing expected", got));
            return;
         end
         want = expected_levels.pop_front();
         check_field("right_enable", 8'(got.right_enable), 8'(want.right_enable));
         check_field("right_dir_a", 8'(got.right_dir_a), 8'(want.right_dir_a));
         check_field("right_dir_b", 8'(got.right_dir_b), 8'(want.right_dir_b));
         check_field("right_duty", got.right_duty, want.right_duty);
         check_field("left_enable", 8'(got.left_enable), 8'(want.left_enable));
         check_field("left_dir_a", 8'(got.left_dir_a), 8'(want.left_dir_a));
         check_field("left_dir_b", 8'(got.left_dir_b), 8'(want.left_dir_b));
         check_field("left_duty", got.left_duty, want.left_duty);
      endtask

      function int pending();
         return expected_levels.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [7:0]            csr_wdata;

   bridge_level_board board;
   int req_gap_max   = 14;
   int rsp_stall_max = 14;
   int known_sent;

   differential_drive_ramp_decoder_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Bound the run
   initial begin
      #5_000_000;
      $display("tb_differential_drive_ramp_decoder_core: FAIL");
      $finish;
   end

   // Hold valid until the beat is taken, then note it in the board
   task send_beat(req_type r);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      board.apply_command(r);
      if (r.command <= CMD_RVEER_R) known_sent++;
   endtask

   task send(logic [3:0] cmd, logic [7:0] spd, logic urg);
      req_type r;
      r.command = cmd;
      r.speed   = spd;
      r.urgent  = urg;
      send_beat(r);
   endtask

   // Drop valid and wait until every expected beat has come back
   task finish_phase();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   // Write both registers; upper bits of the driver type write are junk
   task configure(logic [7:0] min_spd, logic drv_type);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_MIN_SPEED;
      csr_wdata <= min_spd;
      @(posedge clock);
      board.min_speed = min_spd;
      csr_addr  <= CSR_DRIVER_TYPE;
      csr_wdata <= {7'($urandom_range(0, 127)), drv_type};
      @(posedge clock);
      board.driver_type = drv_type;
      csr_we <= 1'b0;
   endtask

   // Run of forward and veer beats near the ramp start so the ramp saturates
   task ramp_run();
      int          len;
      int          pick;
      int unsigned spd;
      logic [3:0]  cmd;
      len = $urandom_range(6, 40);
      repeat (len) begin
         pick = $urandom_range(0, 2);
         cmd  = (pick == 0) ? CMD_FWD : (pick == 1) ? CMD_VEER_L : CMD_VEER_R;
         case ($urandom_range(0, 7))
            0:       spd = $urandom_range(0, 255);
            1:       spd = $urandom_range(0, board.min_speed);
            default: spd = board.min_speed + $urandom_range(0, 3);
         endcase
         if (spd > 255) spd = 255;
         send(cmd, 8'(spd), $urandom_range(0, 9) == 0);
      end
   endtask

   task noise();
      repeat ($urandom_range(1, 4))
         send(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
              1'($urandom_range(0, 1)));
   endtask

   // Accept rsp beats with random stalls
   task receive_levels();
      int stall;
      forever begin
         stall = $urandom_range(0, rsp_stall_max);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         board.check_levels(rsp_data);
      end
   endtask

   initial begin
      board = new();
      req_valid <= 1'b0;
      req_data  <= '0;
      rsp_ready <= 1'b0;
      csr_we    <= 1'b0;
      csr_addr  <= '0;
      csr_wdata <= '0;
      reset     <= 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      fork
         receive_levels();
      join_none

      // Directed: every command at reset settings, ramp from zero
      send(CMD_FWD, 8'd255, 1'b0);
      send(CMD_FWD, 8'd255, 1'b0);
      send(CMD_VEER_L, 8'd255, 1'b0);
      send(CMD_VEER_R, 8'd0, 1'b0);
      send(CMD_FWD, 8'd255, 1'b1);
      send(CMD_VEER_L, 8'd255, 1'b1);
      send(CMD_VEER_R, 8'd255, 1'b1);
      send(CMD_REV, 8'd255, 1'b0);
      send(CMD_STOP, 8'd0, 1'b1);
      send(CMD_COAST, 8'd77, 1'b0);
      send(CMD_CCW, 8'd128, 1'b1);
      send(CMD_CW, 8'd1, 1'b0);
      send(CMD_RVEER_L, 8'd255, 1'b0);
      send(CMD_RVEER_R, 8'd254, 1'b1);
      send(4'd10, 8'd255, 1'b0);
      send(4'd15, 8'd255, 1'b1);
      finish_phase();

      // Directed: bridge without enable pin, speed below ramp start
      configure(8'd200, 1'b1);
      send(CMD_STOP, 8'd255, 1'b0);
      send(CMD_COAST, 8'd0, 1'b0);
      send(CMD_FWD, 8'd100, 1'b0);
      send(CMD_FWD, 8'd255, 1'b0);
      send(CMD_VEER_R, 8'd255, 1'b0);
      finish_phase();

      // Directed: change registers mid ramp, counter carries on
      configure(8'd255, 1'b0);
      send(CMD_FWD, 8'd255, 1'b0);
      send(CMD_VEER_L, 8'd255, 1'b0);
      finish_phase();

      // Random phases across register extremes, some without idling
      for (int p = 0; p < 6; p++) begin
         case (p)
            0:       configure(8'd0, 1'b1);
            1:       configure(8'd255, 1'b0);
            2:       configure(8'd255, 1'b1);
            3:       configure(8'd0, 1'b0);
            default: configure(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         endcase
         req_gap_max   = (p == 2 || p == 5) ? 0 : 14;
         rsp_stall_max = (p == 3 || p == 5) ? 0 : 14;
         known_sent    = 0;
         while (known_sent < PHASE_CMDS) begin
            if ($urandom_range(0, 9) < 7) ramp_run();
            else noise();
         end
         finish_phase();
      end

      // Let the pipeline settle to catch stray beats
      repeat (6) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("tb_differential_drive_ramp_decoder_core: PASS");
      end else begin
         $display("tb_differential_drive_ramp_decoder_core: FAIL");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/ddrd_pkg.sv
rtl/ddrd_decode.sv
rtl/differential_drive_ramp_decoder_core.sv
sim/tb_differential_drive_ramp_decoder_core.sv
